// ===== design/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, record layout and controller/datapath command types for
// the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HEAP_CAPACITY_BYTES = 16384;
  localparam int GRANULE_BYTES       = 8;
  localparam int HEADER_BYTES        = 24;
  localparam int NGRAN               = HEAP_CAPACITY_BYTES / GRANULE_BYTES;
  localparam int GIDX_W              = $clog2(NGRAN);
  localparam int HDR_G               = (HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
  localparam int HDR_B               = HDR_G * GRANULE_BYTES;
  localparam int MIN_BLOCK           = HDR_B + GRANULE_BYTES;
  localparam int MIN_G               = MIN_BLOCK / GRANULE_BYTES;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_FREE   = 2'd2,
    OP_EXTEND = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_INIT    = 3'd1,
    ST_BAD_ARGS    = 3'd2,
    ST_BAD_PTR     = 3'd3,
    ST_NOT_BLOCK   = 3'd4,
    ST_DOUBLE_FREE = 3'd5,
    ST_NO_FIT      = 3'd6
  } status_t;

  typedef struct packed {
    logic              mark;
    logic              used;
    logic [GIDX_W-1:0] size;
  } rec_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLR_STEP,
    DP_INIT_SET,
    DP_WALK_START,
    DP_RD_G,
    DP_RD_B,
    DP_RD_NX,
    DP_STEP,
    DP_FAIL,
    DP_A_SPLIT,
    DP_A_MARK,
    DP_L_EV,
    DP_L_DONE,
    DP_F_SAVE,
    DP_KEEP,
    DP_F_BWR,
    DP_F_NXMERGE,
    DP_CLR_G,
    DP_F_PMERGE,
    DP_CLR_B,
    DP_E_APPLY,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    set_status;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    heap_ready;
    logic    init_bad;
    logic    free_bad_ptr;
    logic    free_misaligned;
    logic    ext_bad;
    logic    g_lt_end;
    logic    g_lt_b;
    logic    nx_lt_end;
    logic    rd_mark;
    logic    rd_used;
    logic    fit;
    logic    has_prev;
    logic    prev_used;
    logic    clr_last;
  } dp_stat_t;

endpackage

// ===== design/ffha_if.sv =====
// ----------------------------------------------------------------------------
// ffha_in_if / ffha_out_if
// Valid/ready channels carrying one operation beat and one reply beat.
// ----------------------------------------------------------------------------
interface ffha_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [14:0] request_bytes;
  logic [13:0] payload_offset;
  logic [13:0] region_start;
  logic [14:0] region_bytes;

  modport source (output valid, output opcode, output request_bytes,
                  output payload_offset, output region_start, output region_bytes,
                  input ready);
  modport sink   (input valid, input opcode, input request_bytes,
                  input payload_offset, input region_start, input region_bytes,
                  output ready);
endinterface

interface ffha_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [13:0] result_offset;
  logic [14:0] used_total;
  logic [14:0] free_total;
  logic [14:0] largest_free_block;
  logic [31:0] allocations_done;
  logic [31:0] releases_done;
  logic [31:0] failures_seen;
  logic [31:0] extensions_done;

  modport source (output valid, output status, output result_offset, output used_total,
                  output free_total, output largest_free_block, output allocations_done,
                  output releases_done, output failures_seen, output extensions_done,
                  input ready);
  modport sink   (input valid, input status, input result_offset, input used_total,
                  input free_total, input largest_free_block, input allocations_done,
                  input releases_done, input failures_seen, input extensions_done,
                  output ready);
endinterface

// ===== design/ffha_datapath.sv =====
// ----------------------------------------------------------------------------
// ffha_datapath
// Block record memory, walk pointers, byte totals, event counters and the
// reply register, driven one micro-operation per cycle by the controller.
// ----------------------------------------------------------------------------
module ffha_datapath
  import ffha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata,
  input  logic [1:0]  opcode,
  input  logic [14:0] request_bytes,
  input  logic [13:0] payload_offset,
  input  logic [13:0] region_start,
  input  logic [14:0] region_bytes,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic [2:0]  status,
  output logic [13:0] result_offset,
  output logic [14:0] used_total,
  output logic [14:0] free_total,
  output logic [14:0] largest_free_block,
  output logic [31:0] allocations_done,
  output logic [31:0] releases_done,
  output logic [31:0] failures_seen,
  output logic [31:0] extensions_done
);

  rec_t              heap_mem [NGRAN];
  rec_t              rd;
  logic              mem_we, mem_re;
  logic [GIDX_W-1:0] mem_wa, mem_ra;
  rec_t              mem_wd;

  logic [14:0]       initial_bytes;
  opcode_t           op_q;
  logic [14:0]       req_q;
  logic [13:0]       off_q;
  logic [13:0]       rs_q;
  logic [14:0]       rb_q;
  logic [GIDX_W:0]   g;
  logic [GIDX_W-1:0] prev;
  rec_t              prev_rec;
  logic              has_prev;
  logic [GIDX_W-1:0] cur_sz;
  logic [GIDX_W-1:0] best;
  logic [GIDX_W-1:0] clr_cnt;
  logic [GIDX_W:0]   heap_end;
  logic              heap_ready;
  logic [14:0]       used_tot, free_tot, largest;
  logic [31:0]       cnt_alloc, cnt_free, cnt_fail, cnt_ext;
  status_t           status_q;
  logic [13:0]       res_q;

  logic [15:0]       req_sum;
  logic [12:0]       needg_raw, needg;
  logic [GIDX_W-1:0] left;
  logic              fit, split;
  logic [GIDX_W:0]   g_next;
  logic [14:0]       init_size, endb, ext_size;
  logic [13:0]       off_hb;
  logic [GIDX_W-1:0] b_idx;
  logic [GIDX_W:0]   nx;
  logic [GIDX_W-1:0] nx_merged;
  logic [11:0]       ext_g;

  assign req_sum   = {1'b0, req_q} + 16'd7;
  assign needg_raw = req_sum[15:3];
  assign needg     = (needg_raw == 13'd0) ? 13'd1 : needg_raw;
  assign fit       = !rd.used && ({2'b00, rd.size} >= needg);
  assign left      = rd.size - needg[GIDX_W-1:0];
  assign split     = left >= GIDX_W'(MIN_G);
  assign g_next    = g + (GIDX_W+1)'(HDR_G) + {1'b0, rd.size};
  assign init_size = {initial_bytes[14:3], 3'b000};
  assign endb      = {heap_end, 3'b000};
  assign off_hb    = off_q - 14'(HDR_B);
  assign b_idx     = off_hb[13:3];
  assign nx        = {1'b0, b_idx} + (GIDX_W+1)'(HDR_G) + {1'b0, cur_sz};
  assign nx_merged = cur_sz + GIDX_W'(HDR_G) + rd.size;
  assign ext_size  = {rb_q[14:3], 3'b000};
  assign ext_g     = rb_q[14:3];

  always_comb begin
    stat.op              = op_q;
    stat.heap_ready      = heap_ready;
    stat.init_bad        = (init_size < 15'(MIN_BLOCK)) ||
                           (init_size > 15'(HEAP_CAPACITY_BYTES));
    stat.free_bad_ptr    = (off_q < 14'(HDR_B)) || ({1'b0, off_q} >= endb);
    stat.free_misaligned = (off_q[2:0] != 3'd0);
    stat.ext_bad         = (ext_size < 15'(MIN_BLOCK)) || ({1'b0, rs_q} != endb) ||
                           (ext_size > (15'(HEAP_CAPACITY_BYTES) - endb));
    stat.g_lt_end        = g < heap_end;
    stat.g_lt_b          = g < {1'b0, b_idx};
    stat.nx_lt_end       = nx < heap_end;
    stat.rd_mark         = rd.mark;
    stat.rd_used         = rd.used;
    stat.fit             = fit;
    stat.has_prev        = has_prev;
    stat.prev_used       = prev_rec.used;
    stat.clr_last        = (clr_cnt == '1);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = '0;
    mem_ra = '0;
    mem_wd = '0;
    case (cmd.op)
      DP_CLR_STEP: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt;
      end
      DP_INIT_SET: begin
        mem_we = 1'b1;
        mem_wd = '{mark: 1'b1, used: 1'b0,
                   size: GIDX_W'(init_size[14:3] - 12'(HDR_G))};
      end
      DP_RD_G: begin
        mem_re = 1'b1;
        mem_ra = g[GIDX_W-1:0];
      end
      DP_RD_B: begin
        mem_re = 1'b1;
        mem_ra = b_idx;
      end
      DP_RD_NX: begin
        mem_re = 1'b1;
        mem_ra = nx[GIDX_W-1:0];
      end
      DP_A_SPLIT: begin
        mem_we = split;
        mem_wa = g[GIDX_W-1:0] + GIDX_W'(HDR_G) + needg[GIDX_W-1:0];
        mem_wd = '{mark: 1'b1, used: 1'b0, size: left - GIDX_W'(HDR_G)};
      end
      DP_A_MARK: begin
        mem_we = 1'b1;
        mem_wa = g[GIDX_W-1:0];
        mem_wd = '{mark: 1'b1, used: 1'b1, size: cur_sz};
      end
      DP_F_BWR: begin
        mem_we = 1'b1;
        mem_wa = b_idx;
        mem_wd = '{mark: 1'b1, used: 1'b0, size: cur_sz};
      end
      DP_F_NXMERGE: begin
        mem_we = 1'b1;
        mem_wa = b_idx;
        mem_wd = '{mark: 1'b1, used: 1'b0, size: nx_merged};
      end
      DP_CLR_G: begin
        mem_we = 1'b1;
        mem_wa = g[GIDX_W-1:0];
      end
      DP_F_PMERGE: begin
        mem_we = 1'b1;
        mem_wa = prev;
        mem_wd = '{mark: 1'b1, used: 1'b0,
                   size: prev_rec.size + GIDX_W'(HDR_G) + cur_sz};
      end
      DP_CLR_B: begin
        mem_we = 1'b1;
        mem_wa = b_idx;
      end
      DP_E_APPLY: begin
        mem_we = 1'b1;
        if (!prev_rec.used) begin
          mem_wa = prev;
          mem_wd = '{mark: 1'b1, used: 1'b0, size: prev_rec.size + ext_g[GIDX_W-1:0]};
        end else begin
          mem_wa = heap_end[GIDX_W-1:0];
          mem_wd = '{mark: 1'b1, used: 1'b0, size: GIDX_W'(ext_g - 12'(HDR_G))};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd <= heap_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_bytes <= 15'(HEAP_CAPACITY_BYTES);
      clr_cnt       <= '0;
      heap_end      <= '0;
      heap_ready    <= 1'b0;
      used_tot      <= '0;
      free_tot      <= '0;
      largest       <= '0;
      cnt_alloc     <= '0;
      cnt_free      <= '0;
      cnt_fail      <= '0;
      cnt_ext       <= '0;
      has_prev      <= 1'b0;
    end else begin
      if (cfg_we) begin
        initial_bytes <= cfg_wdata;
      end
      if (cmd.set_status) begin
        status_q <= cmd.status;
      end
      case (cmd.op)
        DP_LOAD: begin
          op_q  <= opcode_t'(opcode);
          req_q <= request_bytes;
          off_q <= payload_offset;
          rs_q  <= region_start;
          rb_q  <= region_bytes;
          res_q <= '0;
        end
        DP_CLR_STEP: clr_cnt <= clr_cnt + GIDX_W'(1);
        DP_INIT_SET: begin
          heap_end   <= init_size[14:3];
          used_tot   <= '0;
          free_tot   <= init_size - 15'(HDR_B);
          largest    <= init_size - 15'(HDR_B);
          cnt_alloc  <= '0;
          cnt_free   <= '0;
          cnt_fail   <= '0;
          cnt_ext    <= '0;
          heap_ready <= 1'b1;
        end
        DP_WALK_START: begin
          g        <= '0;
          best     <= '0;
          has_prev <= 1'b0;
        end
        DP_RD_NX: g <= nx;
        DP_STEP:  g <= g_next;
        DP_FAIL:  cnt_fail <= cnt_fail + 32'd1;
        DP_A_SPLIT: begin
          cur_sz <= split ? needg[GIDX_W-1:0] : rd.size;
          if (split) begin
            free_tot <= free_tot - 15'(HDR_B);
          end
        end
        DP_A_MARK: begin
          used_tot  <= used_tot + {1'b0, cur_sz, 3'b000};
          free_tot  <= free_tot - {1'b0, cur_sz, 3'b000};
          cnt_alloc <= cnt_alloc + 32'd1;
          res_q     <= {g[GIDX_W-1:0], 3'b000} + 14'(HDR_B);
        end
        DP_L_EV: begin
          if (!rd.used && (rd.size > best)) begin
            best <= rd.size;
          end
          g <= g_next;
        end
        DP_L_DONE: largest <= {1'b0, best, 3'b000};
        DP_F_SAVE: begin
          cur_sz   <= rd.size;
          g        <= '0;
          has_prev <= 1'b0;
        end
        DP_KEEP: begin
          prev     <= g[GIDX_W-1:0];
          prev_rec <= rd;
          has_prev <= 1'b1;
          g        <= g_next;
        end
        DP_F_BWR: begin
          used_tot <= used_tot - {1'b0, cur_sz, 3'b000};
          free_tot <= free_tot + {1'b0, cur_sz, 3'b000};
          cnt_free <= cnt_free + 32'd1;
        end
        DP_F_NXMERGE: begin
          cur_sz   <= nx_merged;
          free_tot <= free_tot + 15'(HDR_B);
        end
        DP_F_PMERGE: free_tot <= free_tot + 15'(HDR_B);
        DP_E_APPLY: begin
          heap_end <= heap_end + ext_g;
          free_tot <= prev_rec.used ? free_tot + ext_size - 15'(HDR_B)
                                    : free_tot + ext_size;
          cnt_ext  <= cnt_ext + 32'd1;
        end
        DP_EMIT: begin
          status             <= status_q;
          result_offset      <= res_q;
          used_total         <= used_tot;
          free_total         <= free_tot;
          largest_free_block <= largest;
          allocations_done   <= cnt_alloc;
          releases_done      <= cnt_free;
          failures_seen      <= cnt_fail;
          extensions_done    <= cnt_ext;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl
// Operation sequencer: clearing sweeps, chain walks, splits, merges and the
// reply handshake.
// ----------------------------------------------------------------------------
module ffha_ctrl
  import ffha_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_RST_CLR, S_IDLE, S_DISPATCH, S_INIT_CLR, S_INIT_WR,
    S_A_RD, S_A_EV, S_A_MARK,
    S_F_CHK, S_F_RD, S_F_EV, S_F_NXRD, S_F_NXEV, S_F_NXCLR, S_F_PREV, S_F_PCLR,
    S_E_RD, S_E_EV,
    S_L_START, S_L_RD, S_L_EV,
    S_DONE
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '{op: DP_NOP, set_status: 1'b0, status: ST_OK};
    unique case (state)
      S_RST_CLR: begin
        cmd.op = DP_CLR_STEP;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = DP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next     = S_DONE;
        cmd.set_status = 1'b1;
        if (stat.op == OP_INIT) begin
          if (stat.init_bad) cmd.status = ST_BAD_ARGS;
          else begin
            cmd.set_status = 1'b0;
            state_next     = S_INIT_CLR;
          end
        end else if (!stat.heap_ready) begin
          cmd.status = ST_NOT_INIT;
        end else begin
          unique case (stat.op)
            OP_ALLOC: begin
              cmd.set_status = 1'b0;
              cmd.op         = DP_WALK_START;
              state_next     = S_A_RD;
            end
            OP_FREE: begin
              if (stat.free_bad_ptr) cmd.status = ST_BAD_PTR;
              else if (stat.free_misaligned) cmd.status = ST_NOT_BLOCK;
              else begin
                cmd.set_status = 1'b0;
                cmd.op         = DP_RD_B;
                state_next     = S_F_CHK;
              end
            end
            default: begin
              if (stat.ext_bad) cmd.status = ST_BAD_ARGS;
              else begin
                cmd.set_status = 1'b0;
                cmd.op         = DP_WALK_START;
                state_next     = S_E_RD;
              end
            end
          endcase
        end
      end
      S_INIT_CLR: begin
        cmd.op = DP_CLR_STEP;
        if (stat.clr_last) state_next = S_INIT_WR;
      end
      S_INIT_WR: begin
        cmd        = '{op: DP_INIT_SET, set_status: 1'b1, status: ST_OK};
        state_next = S_DONE;
      end
      S_A_RD: begin
        if (stat.g_lt_end) begin
          cmd.op     = DP_RD_G;
          state_next = S_A_EV;
        end else begin
          cmd        = '{op: DP_FAIL, set_status: 1'b1, status: ST_NO_FIT};
          state_next = S_DONE;
        end
      end
      S_A_EV: begin
        if (stat.fit) begin
          cmd.op     = DP_A_SPLIT;
          state_next = S_A_MARK;
        end else begin
          cmd.op     = DP_STEP;
          state_next = S_A_RD;
        end
      end
      S_A_MARK: begin
        cmd        = '{op: DP_A_MARK, set_status: 1'b1, status: ST_OK};
        state_next = S_L_START;
      end
      S_F_CHK: begin
        cmd.set_status = 1'b1;
        state_next     = S_DONE;
        if (!stat.rd_mark) cmd.status = ST_NOT_BLOCK;
        else if (!stat.rd_used) cmd.status = ST_DOUBLE_FREE;
        else begin
          cmd.set_status = 1'b0;
          cmd.op         = DP_F_SAVE;
          state_next     = S_F_RD;
        end
      end
      S_F_RD: begin
        if (stat.g_lt_b) begin
          cmd.op     = DP_RD_G;
          state_next = S_F_EV;
        end else begin
          cmd        = '{op: DP_F_BWR, set_status: 1'b1, status: ST_OK};
          state_next = S_F_NXRD;
        end
      end
      S_F_EV: begin
        cmd.op     = DP_KEEP;
        state_next = S_F_RD;
      end
      S_F_NXRD: begin
        if (stat.nx_lt_end) begin
          cmd.op     = DP_RD_NX;
          state_next = S_F_NXEV;
        end else begin
          state_next = S_F_PREV;
        end
      end
      S_F_NXEV: begin
        if (!stat.rd_used) begin
          cmd.op     = DP_F_NXMERGE;
          state_next = S_F_NXCLR;
        end else begin
          state_next = S_F_PREV;
        end
      end
      S_F_NXCLR: begin
        cmd.op     = DP_CLR_G;
        state_next = S_F_PREV;
      end
      S_F_PREV: begin
        if (stat.has_prev && !stat.prev_used) begin
          cmd.op     = DP_F_PMERGE;
          state_next = S_F_PCLR;
        end else begin
          state_next = S_L_START;
        end
      end
      S_F_PCLR: begin
        cmd.op     = DP_CLR_B;
        state_next = S_L_START;
      end
      S_E_RD: begin
        if (stat.g_lt_end) begin
          cmd.op     = DP_RD_G;
          state_next = S_E_EV;
        end else begin
          cmd        = '{op: DP_E_APPLY, set_status: 1'b1, status: ST_OK};
          state_next = S_L_START;
        end
      end
      S_E_EV: begin
        cmd.op     = DP_KEEP;
        state_next = S_E_RD;
      end
      S_L_START: begin
        cmd.op     = DP_WALK_START;
        state_next = S_L_RD;
      end
      S_L_RD: begin
        if (stat.g_lt_end) begin
          cmd.op     = DP_RD_G;
          state_next = S_L_EV;
        end else begin
          cmd.op     = DP_L_DONE;
          state_next = S_DONE;
        end
      end
      S_L_EV: begin
        cmd.op     = DP_L_EV;
        state_next = S_L_RD;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.op     = DP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RST_CLR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && slot_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ===== design/first_fit_heap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit heap allocator with block splitting and neighbor coalescing.
// alloc/free/extend walk the block chain and, when they succeed, rescan it
//   for the largest free block
// init replies after a 2048-entry record sweep
// one operation in flight; the next beat is taken while a reply waits
// reset runs the same 2048-entry sweep before the first beat is taken
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core
  import ffha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata,
  ffha_in_if.sink     in_ch,
  ffha_out_if.source  out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffha_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .opcode             (in_ch.opcode),
    .request_bytes      (in_ch.request_bytes),
    .payload_offset     (in_ch.payload_offset),
    .region_start       (in_ch.region_start),
    .region_bytes       (in_ch.region_bytes),
    .cmd                (cmd),
    .stat               (stat),
    .status             (out_ch.status),
    .result_offset      (out_ch.result_offset),
    .used_total         (out_ch.used_total),
    .free_total         (out_ch.free_total),
    .largest_free_block (out_ch.largest_free_block),
    .allocations_done   (out_ch.allocations_done),
    .releases_done      (out_ch.releases_done),
    .failures_seen      (out_ch.failures_seen),
    .extensions_done    (out_ch.extensions_done)
  );

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for first_fit_heap_allocator_core. A short table of
// directed operations is followed by random init/alloc/free/extend traffic. Every
// reply is checked field by field against a behavioral model of the heap,
// with both channels throttled and a long reply stall to back up the input.
// ----------------------------------------------------------------------------
module tb
  import ffha_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t     status;
    logic [13:0] result_offset;
    logic [14:0] used_total;
    logic [14:0] free_total;
    logic [14:0] big_free;
    logic [31:0] allocs;
    logic [31:0] releases;
    logic [31:0] failures;
    logic [31:0] extensions;
  } reply_t;

  typedef struct {
    int      cfg;
    opcode_t op;
    int      req;
    int      off;
    int      rs;
    int      rb;
    status_t st;
  } op_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [14:0] cfg_wdata = '0;

  ffha_in_if  in_ch();
  ffha_out_if out_ch();

  first_fit_heap_allocator_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #4 clk = ~clk;

  // heap model state
  bit          blk_mark[NGRAN];
  bit          blk_used[NGRAN];
  int unsigned blk_size[NGRAN];
  int unsigned heap_end;
  bit          heap_on;
  int unsigned init_size_reg;
  int unsigned m_used, m_free, largest_bytes;
  int unsigned n_alloc, n_free, n_fail, n_ext;
  int unsigned live_ptrs[$];
  int unsigned old_ptrs[$];

  reply_t pending_replies[$];
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     hold_cycles = 0;

  function automatic int unsigned next_blk(int unsigned g);
    return g + HDR_G + blk_size[g];
  endfunction

  function automatic void rescan_largest();
    int unsigned g = 0, best = 0;
    while (g < heap_end && g < NGRAN) begin
      if (!blk_used[g] && blk_size[g] > best) best = blk_size[g];
      g = next_blk(g);
    end
    largest_bytes = best * GRANULE_BYTES;
  endfunction

  function automatic status_t model_init();
    int unsigned sz = init_size_reg & ~32'd7;
    if (sz < MIN_BLOCK || sz > HEAP_CAPACITY_BYTES) return ST_BAD_ARGS;
    for (int i = 0; i < NGRAN; i++) begin
      blk_mark[i] = 0;
      blk_used[i] = 0;
      blk_size[i] = 0;
    end
    blk_mark[0] = 1;
    blk_size[0] = (sz - HDR_B) / GRANULE_BYTES;
    heap_end = sz / GRANULE_BYTES;
    m_used = 0;
    m_free = sz - HDR_B;
    largest_bytes = sz - HDR_B;
    n_alloc = 0; n_free = 0; n_fail = 0; n_ext = 0;
    heap_on = 1;
    live_ptrs.delete();
    return ST_OK;
  endfunction

  function automatic status_t model_alloc(int unsigned req, output int unsigned res);
    int unsigned need = (req + 7) & ~32'd7;
    int unsigned needg, g = 0, sz, left, r;
    res = 0;
    if (need == 0) need = GRANULE_BYTES;
    needg = need / GRANULE_BYTES;
    while (g < heap_end && g < NGRAN) begin
      sz = blk_size[g];
      if (!blk_used[g] && sz >= needg) begin
        left = (sz - needg) * GRANULE_BYTES;
        if (left >= MIN_BLOCK) begin
          r = g + HDR_G + needg;
          if (r < NGRAN) begin
            blk_mark[r] = 1;
            blk_used[r] = 0;
            blk_size[r] = (left - HDR_B) / GRANULE_BYTES;
          end
          sz = needg;
          m_free -= HDR_B;
        end
        blk_used[g] = 1;
        blk_size[g] = sz;
        m_used += sz * GRANULE_BYTES;
        m_free -= sz * GRANULE_BYTES;
        n_alloc++;
        rescan_largest();
        res = g * GRANULE_BYTES + HDR_B;
        return ST_OK;
      end
      g = next_blk(g);
    end
    n_fail++;
    return ST_NO_FIT;
  endfunction

  function automatic status_t heap_release(int unsigned off);
    int unsigned hb, b, g, prv = 0, nx, sz;
    bit has_prev = 0;
    if (off < HDR_B || off >= heap_end * GRANULE_BYTES) return ST_BAD_PTR;
    hb = off - HDR_B;
    if (hb % GRANULE_BYTES != 0) return ST_NOT_BLOCK;
    b = hb / GRANULE_BYTES;
    if (b >= NGRAN || !blk_mark[b]) return ST_NOT_BLOCK;
    if (!blk_used[b]) return ST_DOUBLE_FREE;
    g = 0;
    while (g < b && g < NGRAN) begin
      prv = g;
      has_prev = 1;
      g = next_blk(g);
    end
    sz = blk_size[b];
    blk_used[b] = 0;
    m_used -= sz * GRANULE_BYTES;
    m_free += sz * GRANULE_BYTES;
    n_free++;
    nx = next_blk(b);
    if (nx < heap_end && nx < NGRAN && !blk_used[nx]) begin
      sz += HDR_G + blk_size[nx];
      blk_size[b] = sz;
      blk_mark[nx] = 0;
      m_free += HDR_B;
    end
    if (has_prev && !blk_used[prv]) begin
      blk_size[prv] = blk_size[prv] + HDR_G + sz;
      blk_mark[b] = 0;
      m_free += HDR_B;
    end
    rescan_largest();
    return ST_OK;
  endfunction

  function automatic status_t model_extend(int unsigned start, int unsigned bytes);
    int unsigned sz = bytes & ~32'd7;
    int unsigned endb = heap_end * GRANULE_BYTES;
    int unsigned g = 0, tail = 0, fresh;
    if (sz < MIN_BLOCK) return ST_BAD_ARGS;
    if (start != endb) return ST_BAD_ARGS;
    if (sz > HEAP_CAPACITY_BYTES - endb) return ST_BAD_ARGS;
    while (g < heap_end && g < NGRAN) begin
      tail = g;
      g = next_blk(g);
    end
    fresh = heap_end;
    heap_end += sz / GRANULE_BYTES;
    m_free += sz - HDR_B;
    n_ext++;
    if (!blk_used[tail]) begin
      blk_size[tail] = blk_size[tail] + sz / GRANULE_BYTES;
      m_free += HDR_B;
    end else if (fresh < NGRAN) begin
      blk_mark[fresh] = 1;
      blk_used[fresh] = 0;
      blk_size[fresh] = (sz - HDR_B) / GRANULE_BYTES;
    end
    rescan_largest();
    return ST_OK;
  endfunction

  function automatic reply_t heap_step(opcode_t op, int unsigned req, int unsigned off,
                                       int unsigned rs, int unsigned rb);
    reply_t      r;
    int unsigned res = 0;
    if (op == OP_INIT) r.status = model_init();
    else if (!heap_on) r.status = ST_NOT_INIT;
    else if (op == OP_ALLOC) begin
      r.status = model_alloc(req, res);
      if (r.status == ST_OK) live_ptrs.push_back(res);
    end else if (op == OP_FREE) begin
      r.status = heap_release(off);
      if (r.status == ST_OK) begin
        foreach (live_ptrs[i]) if (live_ptrs[i] == off) begin
          live_ptrs.delete(i);
          break;
        end
        old_ptrs.push_back(off);
      end
    end else r.status = model_extend(rs, rb);
    r.result_offset = res[13:0];
    r.used_total    = m_used[14:0];
    r.free_total    = m_free[14:0];
    r.big_free      = largest_bytes[14:0];
    r.allocs        = n_alloc;
    r.releases      = n_free;
    r.failures      = n_fail;
    r.extensions    = n_ext;
    return r;
  endfunction

  // sender: one beat per call, may leave valid low for a while first
  task automatic send_op(opcode_t op, int unsigned req, int unsigned off,
                         int unsigned rs, int unsigned rb, int fixed_st);
    reply_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid          = 1'b1;
    in_ch.opcode         = op;
    in_ch.request_bytes  = req[14:0];
    in_ch.payload_offset = off[13:0];
    in_ch.region_start   = rs[13:0];
    in_ch.region_bytes   = rb[14:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = heap_step(op, req[14:0], off[13:0], rs[13:0], rb[14:0]);
    if (fixed_st >= 0) r.status = status_t'(fixed_st);
    pending_replies.push_back(r);
    @(negedge clk);
  endtask

  task automatic write_init_size(int unsigned v);
    in_ch.valid = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v[14:0];
    init_size_reg = v & 32'h7fff;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_op();
    int unsigned k = $urandom_range(99);
    int unsigned req = $urandom_range(0, 32767);
    int unsigned off = $urandom_range(0, 16383);
    int unsigned rs = $urandom_range(0, 16383);
    int unsigned rb = $urandom_range(0, 32767);
    if (k < 2) send_op(OP_INIT, req, off, rs, rb, -1);
    else if (k < 47) begin
      case ($urandom_range(9))
        0:       req = $urandom_range(0, 2048);
        1:       ;
        default: req = $urandom_range(0, 128);
      endcase
      send_op(OP_ALLOC, req, off, rs, rb, -1);
    end else if (k < 82) begin
      if (live_ptrs.size() > 0 && $urandom_range(9) < 8)
        off = live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
      else if (old_ptrs.size() > 0 && $urandom_range(1))
        off = old_ptrs[$urandom_range(0, old_ptrs.size() - 1)];
      send_op(OP_FREE, req, off, rs, rb, -1);
    end else if (k < 94) begin
      if ($urandom_range(3) != 0) begin
        rs = heap_end * GRANULE_BYTES;
        rb = $urandom_range(24, 512);
      end
      send_op(OP_EXTEND, req, off, rs, rb, -1);
    end else
      send_op(opcode_t'($urandom_range(3)), req, off, rs, rb, -1);
  endtask

  op_row_t rows[] = '{
    '{-1, OP_ALLOC,  0,     24,    0,     0,     ST_NOT_INIT},
    '{-1, OP_FREE,   0,     24,    0,     0,     ST_NOT_INIT},
    '{-1, OP_EXTEND, 0,     0,     0,     64,    ST_NOT_INIT},
    '{-1, OP_INIT,   0,     0,     0,     0,     ST_OK},
    '{-1, OP_ALLOC,  0,     0,     0,     0,     ST_OK},
    '{-1, OP_ALLOC,  16384, 0,     0,     0,     ST_NO_FIT},
    '{-1, OP_ALLOC,  32767, 0,     0,     0,     ST_NO_FIT},
    '{-1, OP_FREE,   0,     0,     0,     0,     ST_BAD_PTR},
    '{-1, OP_FREE,   0,     16383, 0,     0,     ST_NOT_BLOCK},
    '{-1, OP_FREE,   0,     25,    0,     0,     ST_NOT_BLOCK},
    '{-1, OP_ALLOC,  8,     0,     0,     0,     ST_OK},
    '{-1, OP_ALLOC,  8,     0,     0,     0,     ST_OK},
    '{-1, OP_FREE,   0,     56,    0,     0,     ST_OK},
    '{-1, OP_FREE,   0,     24,    0,     0,     ST_OK},
    '{-1, OP_FREE,   0,     56,    0,     0,     ST_NOT_BLOCK},
    '{-1, OP_FREE,   0,     24,    0,     0,     ST_DOUBLE_FREE},
    '{-1, OP_EXTEND, 0,     0,     16383, 32,    ST_BAD_ARGS},
    '{31, OP_INIT,   0,     0,     0,     0,     ST_BAD_ARGS},
    '{32767, OP_INIT, 0,    0,     0,     0,     ST_BAD_ARGS},
    '{0,  OP_INIT,   0,     0,     0,     0,     ST_BAD_ARGS},
    '{32, OP_INIT,   0,     0,     0,     0,     ST_OK},
    '{-1, OP_EXTEND, 0,     0,     32,    8,     ST_BAD_ARGS},
    '{-1, OP_EXTEND, 0,     0,     32,    32,    ST_OK},
    '{256, OP_INIT,  0,     0,     0,     0,     ST_OK},
    '{-1, OP_ALLOC,  232,   0,     0,     0,     ST_OK},
    '{-1, OP_EXTEND, 0,     0,     100,   64,    ST_BAD_ARGS},
    '{-1, OP_EXTEND, 0,     0,     256,   32767, ST_BAD_ARGS},
    '{-1, OP_EXTEND, 0,     0,     256,   64,    ST_OK}
  };

  // reply side: ready throttling and long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    reply_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with nothing outstanding, status %0d", $time, out_ch.status);
        errors++;
      end else begin
        e = pending_replies.pop_front();
        if (out_ch.status !== e.status || out_ch.result_offset !== e.result_offset ||
            out_ch.used_total !== e.used_total || out_ch.free_total !== e.free_total ||
            out_ch.largest_free_block !== e.big_free ||
            out_ch.allocations_done !== e.allocs || out_ch.releases_done !== e.releases ||
            out_ch.failures_seen !== e.failures ||
            out_ch.extensions_done !== e.extensions) begin
          $display("%0t: expected st=%0d off=%0d used=%0d free=%0d big=%0d cnt=%0d/%0d/%0d/%0d",
                   $time, e.status, e.result_offset, e.used_total, e.free_total,
                   e.big_free, e.allocs, e.releases, e.failures, e.extensions);
          $display("%0t: actual   st=%0d off=%0d used=%0d free=%0d big=%0d cnt=%0d/%0d/%0d/%0d",
                   $time, out_ch.status, out_ch.result_offset, out_ch.used_total,
                   out_ch.free_total, out_ch.largest_free_block, out_ch.allocations_done,
                   out_ch.releases_done, out_ch.failures_seen, out_ch.extensions_done);
          errors++;
        end
      end
    end
  end

  initial begin
    #40ms;
    $display("first_fit_heap_allocator_core: mismatch");
    $finish;
  end

  initial begin
    int unsigned sizes[4] = '{256, 1024, 0, 16384};
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_INIT;
    in_ch.request_bytes = '0;
    in_ch.payload_offset = '0;
    in_ch.region_start = '0;
    in_ch.region_bytes = '0;
    out_ch.ready = 1'b0;
    init_size_reg = 16384;
    heap_on = 0;
    heap_end = 0;
    m_used = 0; m_free = 0; largest_bytes = 0;
    n_alloc = 0; n_free = 0; n_fail = 0; n_ext = 0;
    for (int i = 0; i < NGRAN; i++) begin
      blk_mark[i] = 0; blk_used[i] = 0; blk_size[i] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      if (rows[i].cfg >= 0) write_init_size(rows[i].cfg);
      send_op(rows[i].op, rows[i].req, rows[i].off, rows[i].rs, rows[i].rb, rows[i].st);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      if (sizes[ph] == 0) sizes[ph] = $urandom_range(32, 4096);
      write_init_size(sizes[ph]);
      send_op(OP_INIT, 0, 0, 0, 0, -1);
      for (int n = 0; n < 95; n++) begin
        if (ph == 1 && n == 40) begin
          in_ch.valid = 1'b0;
          while (pending_replies.size() != 0) @(posedge clk);
          @(negedge clk);
        end
        if (ph == 0 && n == 30) hold_cycles = 400;
        random_op();
      end
    end
    in_ch.valid = 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("first_fit_heap_allocator_core: match");
    else
      $display("first_fit_heap_allocator_core: mismatch");
    $finish;
  end

endmodule
